// File: design/sfla_pkg.sv
// Shared types and constants for the slot free-list allocator.
`timescale 1ns / 1ps

package sfla_pkg;

    localparam int SLOT_W     = 10;
    localparam int SLOT_LIMIT = 1024;
    localparam int LINK_DEPTH = 1 << SLOT_W;
    localparam int TDATA_W    = 16;
    localparam int TUSER_W    = 2;

    localparam logic [SLOT_W:0]   SLOT_LIMIT_CMP = (SLOT_W + 1)'(SLOT_LIMIT);
    localparam logic [SLOT_W-1:0] CAPACITY_RESET = SLOT_W'(1023);
    localparam logic [SLOT_W-1:0] NO_SLOT        = '0;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_CHECK = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_OUT_OF_SLOTS = 2'd1,
        ST_BACKING_LOW  = 2'd2,
        ST_OUT_OF_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        action_t           action;
        logic [SLOT_W-1:0] slot;
    } request_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_out;
        status_t           status;
    } result_t;

endpackage

// File: design/sfla_link_ram.sv
// Link store for the free list: one write port and one registered read port.
`timescale 1ns / 1ps

module sfla_link_ram (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [sfla_pkg::SLOT_W-1:0] wr_addr,
    input  logic [sfla_pkg::SLOT_W-1:0] wr_data,
    input  logic [sfla_pkg::SLOT_W-1:0] rd_addr,
    output logic [sfla_pkg::SLOT_W-1:0] rd_data
);
    import sfla_pkg::*;

    logic [SLOT_W-1:0] mem [LINK_DEPTH];
    logic [SLOT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/sfla_core.sv
// Allocator state and the per-transaction decision logic.
`timescale 1ns / 1ps

module sfla_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [sfla_pkg::SLOT_W-1:0] cfg_data,
    input  logic                        en,
    input  sfla_pkg::request_t          req,
    output sfla_pkg::result_t           res
);
    import sfla_pkg::*;

    logic [SLOT_W-1:0] capacity_reg;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] high_water_reg, high_water_next;
    logic [SLOT_W-1:0] bypass_reg, bypass_next;
    logic              bypass_sel_reg, bypass_sel_next;

    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [SLOT_W-1:0] wr_data;
    logic [SLOT_W-1:0] rd_data;
    logic [SLOT_W-1:0] head_link;
    logic [SLOT_W:0]   bump;

    // The link of the current head is either the last read of the store or,
    // right after a push, the old head that the push just linked behind it.
    assign head_link = bypass_sel_reg ? bypass_reg : rd_data;
    assign bump      = {1'b0, high_water_reg} + (SLOT_W + 1)'(1);

    always_comb
    begin
        head_next       = head_reg;
        high_water_next = high_water_reg;
        bypass_next     = bypass_reg;
        bypass_sel_next = bypass_sel_reg;
        wr_en           = 1'b0;
        wr_addr         = req.slot;
        wr_data         = head_reg;
        res.slot_out    = NO_SLOT;
        res.status      = ST_OK;
        unique case (req.action)
            ACT_ALLOC:
            begin
                if (head_reg != NO_SLOT)
                begin
                    res.slot_out    = head_reg;
                    head_next       = head_link;
                    bypass_sel_next = 1'b0;
                end
                else if (bump >= SLOT_LIMIT_CMP)
                begin
                    res.status = ST_OUT_OF_SLOTS;
                end
                else if (bump > {1'b0, capacity_reg})
                begin
                    res.status = ST_BACKING_LOW;
                end
                else
                begin
                    high_water_next = bump[SLOT_W-1:0];
                    res.slot_out    = bump[SLOT_W-1:0];
                end
            end
            ACT_FREE:
            begin
                if (req.slot != NO_SLOT)
                begin
                    wr_en           = 1'b1;
                    head_next       = req.slot;
                    bypass_next     = head_reg;
                    bypass_sel_next = 1'b1;
                end
            end
            ACT_CHECK:
            begin
                if (req.slot == NO_SLOT || req.slot > high_water_reg)
                begin
                    res.status = ST_OUT_OF_RANGE;
                end
                else
                begin
                    res.slot_out = req.slot;
                end
            end
            ACT_NONE:
            begin
                res.status = ST_OK;
            end
            default:
            begin
                res.status = ST_OK;
            end
        endcase
        if (!en)
        begin
            head_next       = head_reg;
            high_water_next = high_water_reg;
            bypass_next     = bypass_reg;
            bypass_sel_next = bypass_sel_reg;
            wr_en           = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= CAPACITY_RESET;
            head_reg       <= NO_SLOT;
            high_water_reg <= NO_SLOT;
            bypass_reg     <= NO_SLOT;
            bypass_sel_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
            head_reg       <= head_next;
            high_water_reg <= high_water_next;
            bypass_reg     <= bypass_next;
            bypass_sel_reg <= bypass_sel_next;
        end
    end

    sfla_link_ram u_link_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (head_next),
        .rd_data (rd_data)
    );

endmodule

// File: design/slot_free_list_allocator_unit.sv
// Top level of the slot free-list allocator with its input and result registers.
`timescale 1ns / 1ps
//
// Requests arrive on the slave stream: tuser carries the request kind
// (alloc, free, check or none) and tdata carries the slot number. Each request
// produces exactly one result on the master stream, with the slot number
// and a status code in tdata.
// A request is first captured in an input register; the allocator then decides
// it and the result lands in the output register when that register is empty
// or its result is being taken. One request is taken every cycle while the
// result stream does not stall. The head link is kept ready by a registered
// read of the link store, so back-to-back pops never wait.
// The backing capacity register is written through cfg_we and cfg_data; the user
// must write it only while the unit is idle, which the block does not enforce.
// Reset empties the free list, clears the high-water count and sets the
// backing capacity to 1023; the link store itself is not cleared.
// When the receiver stalls, the result is held and the input register holds
// one more request; s_tready then drops until the result is taken.

module slot_free_list_allocator_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [sfla_pkg::SLOT_W-1:0]  cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sfla_pkg::TDATA_W-1:0] s_tdata,  // slot[9:0], zero padding
    input  logic [sfla_pkg::TUSER_W-1:0] s_tuser,  // action[1:0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sfla_pkg::TDATA_W-1:0] m_tdata   // slot_out[9:0], status[11:10], padding
);
    import sfla_pkg::*;

    logic     in_valid_reg;
    request_t in_req_reg;
    logic     out_valid_reg;
    result_t  out_res_reg;
    result_t  core_res;
    logic     advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_req_reg.action <= action_t'(s_tuser);
            in_req_reg.slot   <= s_tdata[SLOT_W-1:0];
        end
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    sfla_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .en       (advance),
        .req      (in_req_reg),
        .res      (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W - SLOT_W - 2){1'b0}}, out_res_reg.status,
                       out_res_reg.slot_out};

endmodule

// File: verif/tb_slot_free_list_allocator_unit.sv
// Self-checking testbench for the slot free-list allocator unit.
`timescale 1ns / 1ps

module tb_slot_free_list_allocator_unit;

    import sfla_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [SLOT_W-1:0]    cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata  = '0;
    logic [TUSER_W-1:0]   s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;

    // Allocator state as the testbench predicts it.
    logic [SLOT_W-1:0]    list_head  = NO_SLOT;
    logic [SLOT_W-1:0]    bump_count = '0;
    logic [SLOT_W-1:0]    capacity   = CAPACITY_RESET;
    logic [SLOT_W-1:0]    link_mem [LINK_DEPTH];
    bit                   on_list  [LINK_DEPTH];

    result_t              pending_results [$];
    logic [SLOT_W-1:0]    held_slots [$];
    result_t              oldest_result;

    int                   error_count = 0;
    int                   cycle_count = 0;
    int                   burst_left  = 0;
    bit                   hold_request = 1'b0;
    int                   hold_left   = 0;
    int                   rx_mode     = 0;
    int                   rx_mode_left = 0;

    slot_free_list_allocator_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_slot_free_list_allocator_unit: done, errors");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic result_t predict_allocation(action_t act, logic [SLOT_W-1:0] s);
        result_t         r;
        logic [SLOT_W:0] bump;
        r.slot_out = NO_SLOT;
        r.status   = ST_OK;
        case (act)
            ACT_ALLOC:
            begin
                if (list_head != NO_SLOT)
                begin
                    r.slot_out = list_head;
                    on_list[list_head] = 1'b0;
                    list_head = link_mem[list_head];
                end
                else
                begin
                    bump = {1'b0, bump_count} + 1'b1;
                    if (bump >= SLOT_LIMIT_CMP)
                        r.status = ST_OUT_OF_SLOTS;
                    else if (bump > {1'b0, capacity})
                        r.status = ST_BACKING_LOW;
                    else
                    begin
                        bump_count = bump[SLOT_W-1:0];
                        r.slot_out = bump[SLOT_W-1:0];
                    end
                end
            end
            ACT_FREE:
            begin
                if (s != NO_SLOT)
                begin
                    link_mem[s] = list_head;
                    list_head = s;
                    on_list[s] = 1'b1;
                end
            end
            ACT_CHECK:
            begin
                if (s == NO_SLOT || s > bump_count)
                    r.status = ST_OUT_OF_RANGE;
                else
                    r.slot_out = s;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Result checker: every master transaction is matched against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result tdata=%h", m_tdata));
            else
            begin
                oldest_result = pending_results.pop_front();
                if (m_tdata[SLOT_W-1:0] !== oldest_result.slot_out)
                    report_mismatch($sformatf("slot_out got %0d expected %0d",
                                              m_tdata[SLOT_W-1:0], oldest_result.slot_out));
                if (m_tdata[SLOT_W+1:SLOT_W] !== oldest_result.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              m_tdata[SLOT_W+1:SLOT_W], oldest_result.status));
            end
        end
    end

    // Receiver: random ready patterns, plus a long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(8, 60);
            end
            rx_mode_left--;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_request(action_t act, logic [SLOT_W-1:0] s);
        int      gap;
        result_t r;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(TDATA_W - SLOT_W){1'b0}}, s};
        do
            @(posedge clk);
        while (!s_tready);
        r = predict_allocation(act, s);
        pending_results.push_back(r);
        if (act == ACT_ALLOC && r.status == ST_OK)
            held_slots.push_back(r.slot_out);
        @(negedge clk);
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(logic [SLOT_W-1:0] value);
        wait_all_results();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        capacity = value;
    endtask

    task automatic send_random_request();
        int                r;
        int                idx;
        logic [SLOT_W-1:0] s;
        r = $urandom_range(0, 99);
        if (r < 40 || (r < 70 && held_slots.size() == 0))
            send_request(ACT_ALLOC, SLOT_W'($urandom_range(0, 1023)));
        else if (r < 70)
        begin
            idx = $urandom_range(0, held_slots.size() - 1);
            s = held_slots[idx];
            held_slots.delete(idx);
            if (on_list[s])
                send_request(ACT_CHECK, s);
            else
                send_request(ACT_FREE, s);
        end
        else if (r < 85)
            send_request(ACT_CHECK, SLOT_W'($urandom_range(0, int'(bump_count) + 2)));
        else if (r < 93)
        begin
            // Free of an arbitrary slot, kept off the list so that it stays acyclic.
            s = SLOT_W'($urandom_range(0, 1023));
            if (s != NO_SLOT && on_list[s])
                send_request(ACT_CHECK, s);
            else
            begin
                for (int i = 0; i < held_slots.size(); i++)
                begin
                    if (held_slots[i] == s)
                    begin
                        held_slots.delete(i);
                        break;
                    end
                end
                send_request(ACT_FREE, s);
            end
        end
        else if (r < 97)
            send_request(ACT_NONE, SLOT_W'($urandom_range(0, 1023)));
        else
            send_request(ACT_CHECK, SLOT_W'($urandom_range(0, 1023)));
    endtask

    task automatic test_request_basics();
        send_request(ACT_CHECK, NO_SLOT);
        send_request(ACT_CHECK, SLOT_W'(1));
        send_request(ACT_CHECK, SLOT_W'(1023));
        send_request(ACT_ALLOC, SLOT_W'(1023));
        send_request(ACT_ALLOC, NO_SLOT);
        send_request(ACT_ALLOC, SLOT_W'(682));
        send_request(ACT_CHECK, SLOT_W'(3));
        send_request(ACT_CHECK, SLOT_W'(4));
        send_request(ACT_FREE, NO_SLOT);
        send_request(ACT_NONE, SLOT_W'(1023));
        send_request(ACT_NONE, NO_SLOT);
    endtask

    task automatic test_free_list_reuse();
        send_request(ACT_FREE, SLOT_W'(2));
        send_request(ACT_FREE, SLOT_W'(1));
        send_request(ACT_ALLOC, NO_SLOT);
        send_request(ACT_ALLOC, NO_SLOT);
        send_request(ACT_ALLOC, NO_SLOT);
        send_request(ACT_FREE, SLOT_W'(1023));
        send_request(ACT_ALLOC, NO_SLOT);
        send_request(ACT_CHECK, SLOT_W'(1023));
        held_slots.delete();
    endtask

    task automatic test_capacity_limits();
        write_capacity('0);
        send_request(ACT_ALLOC, NO_SLOT);
        send_request(ACT_FREE, SLOT_W'(3));
        send_request(ACT_ALLOC, NO_SLOT);
        send_request(ACT_ALLOC, NO_SLOT);
        write_capacity(SLOT_W'(6));
        send_request(ACT_ALLOC, NO_SLOT);
        send_request(ACT_ALLOC, NO_SLOT);
        send_request(ACT_ALLOC, NO_SLOT);
        write_capacity(CAPACITY_RESET);
        held_slots.delete();
    endtask

    task automatic test_backpressure();
        wait_all_results();
        hold_request = 1'b1;
        repeat (40) send_random_request();
        wait_all_results();
    endtask

    task automatic test_random_traffic();
        logic [SLOT_W-1:0] phase_capacity [4];
        phase_capacity[0] = CAPACITY_RESET;
        phase_capacity[1] = '0;
        phase_capacity[2] = SLOT_W'($urandom_range(0, 1023));
        phase_capacity[3] = SLOT_W'($urandom_range(int'(bump_count), int'(bump_count) + 40));
        for (int p = 0; p < 4; p++)
        begin
            write_capacity(phase_capacity[p]);
            repeat (140) send_random_request();
        end
    endtask

    task automatic test_slot_exhaustion();
        write_capacity(CAPACITY_RESET);
        while (!(list_head == NO_SLOT && bump_count == SLOT_W'(1023)))
            send_request(ACT_ALLOC, SLOT_W'($urandom_range(0, 1023)));
        send_request(ACT_ALLOC, NO_SLOT);
        send_request(ACT_ALLOC, SLOT_W'(1023));
        send_request(ACT_CHECK, SLOT_W'(1023));
        // The slot limit must win over a capacity that is also too small.
        write_capacity(SLOT_W'(100));
        send_request(ACT_ALLOC, NO_SLOT);
        write_capacity(CAPACITY_RESET);
        held_slots.delete();
    endtask

    task automatic test_double_free();
        send_request(ACT_FREE, SLOT_W'(7));
        send_request(ACT_FREE, SLOT_W'(7));
        send_request(ACT_ALLOC, NO_SLOT);
        send_request(ACT_ALLOC, NO_SLOT);
        send_request(ACT_ALLOC, NO_SLOT);
        send_request(ACT_FREE, SLOT_W'(9));
        send_request(ACT_ALLOC, NO_SLOT);
        send_request(ACT_ALLOC, NO_SLOT);
        send_request(ACT_ALLOC, NO_SLOT);
        send_request(ACT_CHECK, SLOT_W'(7));
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_request_basics();
        test_free_list_reuse();
        test_capacity_limits();
        test_backpressure();
        test_random_traffic();
        test_slot_exhaustion();
        test_double_free();
        wait_all_results();
        if (error_count == 0)
            $display("tb_slot_free_list_allocator_unit: done, clean");
        else
            $display("tb_slot_free_list_allocator_unit: done, errors");
        $finish;
    end

endmodule

// File: files.f
design/sfla_pkg.sv
design/sfla_link_ram.sv
design/sfla_core.sv
design/slot_free_list_allocator_unit.sv
verif/tb_slot_free_list_allocator_unit.sv
